@@ rtl/pulse_rate_tachometer_defines.svh @@
// Assertion macros shared by the tachometer checker.
`ifndef PULSE_RATE_TACHOMETER_DEFINES_SVH
`define PULSE_RATE_TACHOMETER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PRT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PRT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/prt_pkg.sv @@
// Shared types and constants for the pulse rate tachometer.
`timescale 1ns / 1ps
package prt_pkg;

  localparam int TIME_BITS_DEF   = 32;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam int COUNT_W  = 32;
  localparam int STAMP_W  = 32;
  localparam int RPM_W    = 26;
  localparam int STATUS_W = 2;
  localparam int PPR_W    = 5;

  localparam logic [RPM_W-1:0] RPM_NUM   = 26'd60000000;
  localparam logic [PPR_W-1:0] PPR_RESET = 5'd3;

  localparam logic MODE_PULSE  = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_PULSES = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_TOO_FAST  = 2'd2;

  // Occupancy flags of the job queue
  typedef struct packed {
    logic full;
    logic empty;
  } prt_q_stat_t;

endpackage

@@ rtl/prt_front.sv @@
// Front end: accepts pulse and sample items, keeps counters, queues sample jobs.
`timescale 1ns / 1ps
module prt_front import prt_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_mode,
  input  logic [STAMP_W-1:0]   in_time_us,
  input  prt_q_stat_t          q_stat,
  output logic                 q_push,
  output logic [COUNT_W-1:0]   q_dc,
  output logic [TIME_BITS-1:0] q_dt
);

  logic [COUNT_W-1:0]   pulse_cnt_r, pulse_cnt_nxt;
  logic [TIME_BITS-1:0] last_time_r, last_time_nxt;
  logic [COUNT_W-1:0]   samp_cnt_r, samp_cnt_nxt;
  logic [TIME_BITS-1:0] samp_time_r, samp_time_nxt;
  logic                 accept;

  // Hold items off while no room is left for a sample job
  assign in_stall = q_stat.full;
  assign accept   = in_valid && !in_stall;

  // Differences since the previous sample, wrapping
  assign q_dc   = pulse_cnt_r - samp_cnt_r;
  assign q_dt   = last_time_r - samp_time_r;
  assign q_push = accept && (in_mode == MODE_SAMPLE);

  // Advance counters on a pulse, snapshot them on a sample
  always_comb begin
    pulse_cnt_nxt = pulse_cnt_r;
    last_time_nxt = last_time_r;
    samp_cnt_nxt  = samp_cnt_r;
    samp_time_nxt = samp_time_r;
    if (accept) begin
      if (in_mode == MODE_PULSE) begin
        pulse_cnt_nxt = pulse_cnt_r + COUNT_W'(1);
        last_time_nxt = TIME_BITS'(in_time_us);
      end else begin
        samp_cnt_nxt  = pulse_cnt_r;
        samp_time_nxt = last_time_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_cnt_r <= '0;
      last_time_r <= '0;
      samp_cnt_r  <= '0;
      samp_time_r <= '0;
    end else begin
      pulse_cnt_r <= pulse_cnt_nxt;
      last_time_r <= last_time_nxt;
      samp_cnt_r  <= samp_cnt_nxt;
      samp_time_r <= samp_time_nxt;
    end
  end

endmodule

@@ rtl/prt_queue.sv @@
// Small register queue carrying sample jobs from front end to back end.
`timescale 1ns / 1ps
module prt_queue import prt_pkg::*; #(
  parameter int WIDTH = COUNT_W + TIME_BITS_DEF,
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head_data,
  output prt_q_stat_t      stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign stat.full  = (count_r == CW'(DEPTH));
  assign stat.empty = (count_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head_data  = slot_r[rd_ptr_r];

  // Advance pointers with explicit wrap
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store payload
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ rtl/prt_div.sv @@
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module prt_div import prt_pkg::*; #(
  parameter int NW = TIME_BITS_DEF,
  parameter int DW = COUNT_W
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);

  localparam int CW = $clog2(NW + 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [NW-1:0] quo_r, quo_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] den_r, den_nxt;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  assign done = done_r;
  assign quo  = quo_r;

  // Shift in the next numerator bit and try a subtract
  assign trial = {rem_r, quo_r[NW-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = (trial >= {1'b0, den_r});

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    done_nxt = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(NW);
      quo_nxt  = num;
      rem_nxt  = '0;
      den_nxt  = den;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DW-1:0] : trial[DW-1:0];
      quo_nxt = {quo_r[NW-2:0], ge};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

endmodule

@@ rtl/prt_back.sv @@
// Back end: turns a sample job into rpm and status through up to two divisions.
`timescale 1ns / 1ps
module prt_back import prt_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  prt_q_stat_t          q_stat,
  input  logic [COUNT_W-1:0]   q_dc,
  input  logic [TIME_BITS-1:0] q_dt,
  output logic                 q_pop,
  input  logic [PPR_W-1:0]     ppr,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [RPM_W-1:0]     out_rpm,
  output logic [STATUS_W-1:0]  out_status
);

  localparam int NW = (TIME_BITS > RPM_W) ? TIME_BITS : RPM_W;
  localparam int DW = COUNT_W;
  localparam int PW = RPM_W + PPR_W;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV1 = 5'b00010,
    S_ARM  = 5'b00100,
    S_DIV2 = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t              state_r, state_nxt;
  logic [PW-1:0]       prod_r, prod_nxt;
  logic [RPM_W-1:0]    res_rpm_r, res_rpm_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [RPM_W-1:0]    out_rpm_r, out_rpm_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [PPR_W-1:0]    ppr_eff;
  logic                div_start;
  logic                div_done;
  logic [NW-1:0]       div_num;
  logic [DW-1:0]       div_den;
  logic [NW-1:0]       div_quo;

  // Zero pulses per revolution counts as one
  assign ppr_eff = (ppr == '0) ? PPR_W'(1) : ppr;

  // First pass divides time by count, second divides the rpm constant
  assign div_num = (state_r == S_ARM) ? NW'(RPM_NUM) : NW'(q_dt);
  assign div_den = (state_r == S_ARM) ? DW'(prod_r) : q_dc;

  prt_div #(
    .NW (NW),
    .DW (DW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Sequence one job at a time
  always_comb begin
    state_nxt      = state_r;
    prod_nxt       = prod_r;
    res_rpm_nxt    = res_rpm_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_rpm_nxt    = out_rpm_r;
    out_status_nxt = out_status_r;
    q_pop          = 1'b0;
    div_start      = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (!q_stat.empty) begin
          q_pop = 1'b1;
          if (q_dc == '0) begin
            res_rpm_nxt    = '0;
            res_status_nxt = STATUS_NO_PULSES;
            state_nxt      = S_DONE;
          end else begin
            div_start = 1'b1;
            state_nxt = S_DIV1;
          end
        end
      end
      S_DIV1: begin
        if (div_done) begin
          if (div_quo == '0) begin
            res_rpm_nxt    = '0;
            res_status_nxt = STATUS_TOO_FAST;
            state_nxt      = S_DONE;
          end else if (div_quo > NW'(RPM_NUM)) begin
            res_rpm_nxt    = '0;
            res_status_nxt = STATUS_OK;
            state_nxt      = S_DONE;
          end else begin
            prod_nxt  = PW'(div_quo[RPM_W-1:0]) * PW'(ppr_eff);
            state_nxt = S_ARM;
          end
        end
      end
      S_ARM: begin
        div_start = 1'b1;
        state_nxt = S_DIV2;
      end
      S_DIV2: begin
        if (div_done) begin
          res_rpm_nxt    = div_quo[RPM_W-1:0];
          res_status_nxt = STATUS_OK;
          state_nxt      = S_DONE;
        end
      end
      S_DONE: begin
        // Load the output register once it is free or being drained
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_rpm_nxt    = res_rpm_r;
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r       <= prod_nxt;
    res_rpm_r    <= res_rpm_nxt;
    res_status_r <= res_status_nxt;
    out_rpm_r    <= out_rpm_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_rpm    = out_rpm_r;
  assign out_status = out_status_r;

endmodule

@@ rtl/pulse_rate_tachometer.sv @@
// Top level of the pulse rate tachometer.
// Input channel: in_mode selects a pulse (0) or a sample request (1); in_time_us
// is the microsecond timestamp of a pulse and is ignored for a sample.
// Output channel: one transfer of out_rpm and out_status per sample request,
// none per pulse. Configuration: cfg_wr_en writes cfg_wr_data to pulses per rev.
// A pulse is absorbed by the front-end counters as it is accepted. A sample is
// snapshotted and queued; the back end then runs up to two divisions on the
// shared one-bit-per-cycle divider, first the time-per-pulse division and
// then the rpm division. The back end works on one sample job at a time and
// pops the next only after the result of the last one has been loaded into
// the output register.
// Pulses keep being accepted while a sample is being worked on, until the job
// queue (QUEUE_DEPTH entries) fills; in_stall then holds off all items.
// When the receiver stalls, the result stays in the output register and the
// back end finishes its current job and waits.
// Synchronous reset clears the counters and snapshots, empties the queue,
// drops any pending result and sets pulses per rev to 3.
`timescale 1ns / 1ps
module pulse_rate_tachometer import prt_pkg::*; #(
  parameter int TIME_BITS   = TIME_BITS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_mode,
  input  logic [STAMP_W-1:0]  in_time_us,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [RPM_W-1:0]    out_rpm,
  output logic [STATUS_W-1:0] out_status,
  input  logic                cfg_wr_en,
  input  logic [PPR_W-1:0]    cfg_wr_data
);

  localparam int JOB_W = COUNT_W + TIME_BITS;

  logic [PPR_W-1:0]     ppr_r, ppr_nxt;
  prt_q_stat_t          q_stat;
  logic                 q_push;
  logic                 q_pop;
  logic [COUNT_W-1:0]   push_dc;
  logic [TIME_BITS-1:0] push_dt;
  logic [JOB_W-1:0]     head;

  // Pulses-per-rev register
  assign ppr_nxt = cfg_wr_en ? cfg_wr_data : ppr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ppr_r <= PPR_RESET;
    end else begin
      ppr_r <= ppr_nxt;
    end
  end

  prt_front #(
    .TIME_BITS (TIME_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_mode    (in_mode),
    .in_time_us (in_time_us),
    .q_stat     (q_stat),
    .q_push     (q_push),
    .q_dc       (push_dc),
    .q_dt       (push_dt)
  );

  prt_queue #(
    .WIDTH (JOB_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data ({push_dc, push_dt}),
    .pop       (q_pop),
    .head_data (head),
    .stat      (q_stat)
  );

  prt_back #(
    .TIME_BITS (TIME_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .q_dc       (head[JOB_W-1:TIME_BITS]),
    .q_dt       (head[TIME_BITS-1:0]),
    .q_pop      (q_pop),
    .ppr        (ppr_r),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_rpm    (out_rpm),
    .out_status (out_status)
  );

endmodule

@@ rtl/prt_checker.sv @@
// Port-level checks on the tachometer result channel, bound to the top level.
`timescale 1ns / 1ps
`include "pulse_rate_tachometer_defines.svh"
module prt_checker import prt_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input logic [RPM_W-1:0]    out_rpm,
  input logic [STATUS_W-1:0] out_status
);

  // Stalled result holds
  `PRT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_rpm) && $stable(out_status), "stalled result changed")

  // Only defined status codes leave the block
  `PRT_ASSERT_SAME(a_status_code, out_valid, out_status == STATUS_OK || out_status == STATUS_NO_PULSES || out_status == STATUS_TOO_FAST, "undefined status code")

  // Any error status carries a zero rpm
  `PRT_ASSERT_SAME(a_err_zero, out_valid && out_status != STATUS_OK, out_rpm == '0, "error result with nonzero rpm")

  // Rpm never exceeds the numerator
  `PRT_ASSERT_SAME(a_rpm_range, out_valid, out_rpm <= RPM_NUM, "rpm out of range")

endmodule

bind pulse_rate_tachometer prt_checker u_prt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_rpm    (out_rpm),
  .out_status (out_status)
);
